// File: rtl/core/ma_pkg.sv
package ma_pkg;

    localparam int MAX_FEATURES = 5;
    localparam int NUM_PAIRS    = (MAX_FEATURES * (MAX_FEATURES + 1)) / 2;
    localparam int NUM_WORDS    = 1 + MAX_FEATURES + NUM_PAIRS;
    localparam int ACC_W        = 48;
    localparam int LIN_W        = 32;
    localparam int CNT_W        = 16;
    localparam int IDX_W        = 5;
    localparam int NUM_W        = 3;

    typedef logic [ACC_W-1:0] t_word;

    typedef struct packed {
        logic adv;
        logic acc_en;
        logic clear;
    } t_lane_ctl;

    function automatic logic [NUM_W-1:0] active_count(input logic [NUM_W-1:0] cfg);
        logic [NUM_W-1:0] n;
        n = cfg;
        if (n == '0) begin
            n = NUM_W'(1);
        end
        if (n > NUM_W'(MAX_FEATURES)) begin
            n = NUM_W'(MAX_FEATURES);
        end
        return n;
    endfunction

    function automatic int pair_row(input int p);
        int s;
        int r;
        s = 0;
        r = 0;
        for (int i = 0; i < MAX_FEATURES; i++) begin
            for (int j = i; j < MAX_FEATURES; j++) begin
                if (s == p) begin
                    r = i;
                end
                s++;
            end
        end
        return r;
    endfunction

    function automatic int pair_col(input int p);
        int s;
        int c;
        s = 0;
        c = 0;
        for (int i = 0; i < MAX_FEATURES; i++) begin
            for (int j = i; j < MAX_FEATURES; j++) begin
                if (s == p) begin
                    c = j;
                end
                s++;
            end
        end
        return c;
    endfunction

    // Index of the final word of a readout with n active features.
    function automatic logic [IDX_W-1:0] word_last(input logic [NUM_W-1:0] n);
        logic [IDX_W-1:0] tri_n;
        tri_n = (IDX_W'(n) * (IDX_W'(n) + IDX_W'(1))) >> 1;
        return IDX_W'(n) + tri_n;
    endfunction

    // Maps the k-th word of a readout onto its slot in the full store layout:
    // slot 0 is the count, then every linear sum, then every pair sum.
    function automatic logic [IDX_W-1:0] word_src(input logic [NUM_W-1:0] n,
                                                   input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] ord;
        logic [IDX_W-1:0] slot;
        src  = '0;
        ord  = IDX_W'(n) + IDX_W'(1);
        slot = '0;
        if (k == '0) begin
            src = '0;
        end else if (k <= IDX_W'(n)) begin
            src = k;
        end else begin
            for (int i = 0; i < MAX_FEATURES; i++) begin
                for (int j = i; j < MAX_FEATURES; j++) begin
                    if (i < int'(n) && j < int'(n)) begin
                        if (ord == k) begin
                            src = IDX_W'(1 + MAX_FEATURES) + slot;
                        end
                        ord = ord + IDX_W'(1);
                    end
                    slot = slot + IDX_W'(1);
                end
            end
        end
        return src;
    endfunction

endpackage

// File: rtl/core/ma_pair_lane.sv
module ma_pair_lane
    import ma_pkg::*;
#(
    parameter int FEATURE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_lane_ctl                      i_ctl,
    input  logic                           i_active,
    input  logic signed [FEATURE_BITS-1:0] i_a,
    input  logic signed [FEATURE_BITS-1:0] i_b,
    output logic        [ACC_W-1:0]        o_sum
);

    logic signed [2*FEATURE_BITS-1:0] r_prod;
    logic                             r_active;
    logic        [ACC_W-1:0]          r_acc;
    logic signed [ACC_W-1:0]          prod_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod   <= i_a * i_b;
            r_active <= i_active;
        end
    end

    assign prod_ext = ACC_W'(r_prod);
    assign o_sum    = r_acc + (r_active ? prod_ext : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.clear ? '0 : o_sum;
        end
    end

endmodule

// File: rtl/core/ma_lin_lane.sv
module ma_lin_lane
    import ma_pkg::*;
#(
    parameter int FEATURE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_lane_ctl                      i_ctl,
    input  logic                           i_active,
    input  logic signed [FEATURE_BITS-1:0] i_feat,
    output logic        [LIN_W-1:0]        o_sum
);

    logic signed [LIN_W-1:0] r_feat;
    logic                    r_active;
    logic        [LIN_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_feat   <= LIN_W'(i_feat);
            r_active <= i_active;
        end
    end

    assign o_sum = r_acc + (r_active ? r_feat : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= i_ctl.clear ? '0 : o_sum;
        end
    end

endmodule

// File: rtl/core/ma_readout.sv
module ma_readout
    import ma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_snap,
    input  t_word            i_words [NUM_WORDS],
    input  logic [NUM_W-1:0] i_n,
    input  logic             i_sat,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_word_index,
    output logic [ACC_W-1:0] o_word_value,
    output logic             o_overflow,
    output logic             o_last_word
);

    t_word            r_buf [NUM_WORDS];
    logic [NUM_W-1:0] r_n;
    logic             r_sat;
    logic             r_busy;
    logic [IDX_W-1:0] r_k;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic [ACC_W-1:0] r_out_value;
    logic             r_out_ovf;
    logic             r_out_last;
    logic             out_free;
    logic             emit;
    logic             at_last;

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_busy && out_free;
    assign at_last  = (r_k == word_last(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_snap) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (emit) begin
                r_k <= r_k + IDX_W'(1);
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap) begin
            r_buf <= i_words;
            r_n   <= i_n;
            r_sat <= i_sat;
        end
        if (emit) begin
            r_out_index <= r_k;
            r_out_value <= r_buf[word_src(r_n, r_k)];
            r_out_ovf   <= r_sat;
            r_out_last  <= at_last;
        end
    end

    assign o_busy       = r_busy;
    assign o_valid      = r_out_valid;
    assign o_word_index = r_out_index;
    assign o_word_value = r_out_value;
    assign o_overflow   = r_out_ovf;
    assign o_last_word  = r_out_last;

endmodule

// File: rtl/core/moment_accumulator.sv
// Moment accumulator. Each request on the input channel carries five signed
// features and a last flag; the block counts the request, adds every active
// feature to its linear sum and every upper-triangular product to its pair sum.
// The configuration channel writes the number of active features; it is always
// ready and should only be written while the block is idle.
// One request is accepted per clock while o_stall is low. Each one passes a
// register stage, a multiplier stage in its lane and the accumulate stage,
// so every pair lane has a single multiplier and every lane one adder
// between registers. A request marked last is summed and then copied with
// the count into the readout buffer, which clears the store. The readout
// then sends 1 + n + n(n+1)/2 results, one a cycle while the receiver does
// not stall, through a registered output stage. A further last request
// waits at the accumulate stage while the previous readout is still
// draining, and holds all requests behind it meanwhile.
// When the receiver stalls, the output register holds its result and the
// readout pauses. Reset clears all sums, the count and the overflow flag
// and sets the feature count to five.
module moment_accumulator
    import ma_pkg::*;
#(
    parameter int FEATURE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [FEATURE_BITS-1:0] i_feature_a,
    input  logic signed [FEATURE_BITS-1:0] i_feature_b,
    input  logic signed [FEATURE_BITS-1:0] i_feature_c,
    input  logic signed [FEATURE_BITS-1:0] i_feature_d,
    input  logic signed [FEATURE_BITS-1:0] i_feature_e,
    input  logic                           i_last_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic        [NUM_W-1:0]        i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic        [IDX_W-1:0]        o_word_index,
    output logic signed [ACC_W-1:0]        o_word_value,
    output logic                           o_overflow,
    output logic                           o_last_word
);

    logic        [NUM_W-1:0]        r_num_features;
    logic        [NUM_W-1:0]        num_active;
    logic signed [FEATURE_BITS-1:0] feat_in [MAX_FEATURES];
    logic signed [FEATURE_BITS-1:0] r_s1_feat [MAX_FEATURES];
    logic        [MAX_FEATURES-1:0] r_s1_mask;
    logic                           r_s1_valid;
    logic                           r_s1_last;
    logic                           r_s2_valid;
    logic                           r_s2_last;
    logic        [CNT_W-1:0]        r_count;
    logic                           r_sat;
    logic        [CNT_W-1:0]        n_count;
    logic                           n_sat;
    logic                           cnt_full;
    logic                           busy;
    logic                           adv;
    logic                           snap;
    t_lane_ctl                      lane_ctl;
    logic        [LIN_W-1:0]        lin_sum [MAX_FEATURES];
    logic        [ACC_W-1:0]        pair_sum [NUM_PAIRS];
    t_word                          words [NUM_WORDS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_features <= NUM_W'(MAX_FEATURES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_features <= i_cfg_data;
        end
    end

    assign num_active = active_count(r_num_features);

    assign feat_in[0] = i_feature_a;
    assign feat_in[1] = i_feature_b;
    assign feat_in[2] = i_feature_c;
    assign feat_in[3] = i_feature_d;
    assign feat_in[4] = i_feature_e;

    assign adv     = !(r_s2_valid && r_s2_last && busy);
    assign o_stall = !adv;
    assign snap    = adv && r_s2_valid && r_s2_last;

    assign lane_ctl.adv    = adv;
    assign lane_ctl.acc_en = adv && r_s2_valid;
    assign lane_ctl.clear  = r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_feat <= feat_in;
            r_s1_last <= i_last_item;
            r_s2_last <= r_s1_last;
            for (int i = 0; i < MAX_FEATURES; i++) begin
                r_s1_mask[i] <= (i < int'(num_active));
            end
        end
    end

    assign cnt_full = (r_count == '1);
    assign n_count  = cnt_full ? r_count : r_count + CNT_W'(1);
    assign n_sat    = r_sat | cnt_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sat   <= 1'b0;
        end else if (lane_ctl.acc_en) begin
            r_count <= r_s2_last ? '0 : n_count;
            r_sat   <= r_s2_last ? 1'b0 : n_sat;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_FEATURES; g++) begin : g_lin
            ma_lin_lane #(
                .FEATURE_BITS (FEATURE_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (lane_ctl),
                .i_active (r_s1_mask[g]),
                .i_feat   (r_s1_feat[g]),
                .o_sum    (lin_sum[g])
            );
            assign words[1 + g] = ACC_W'(signed'(lin_sum[g]));
        end

        for (g = 0; g < NUM_PAIRS; g++) begin : g_pair
            localparam int ROW = pair_row(g);
            localparam int COL = pair_col(g);
            ma_pair_lane #(
                .FEATURE_BITS (FEATURE_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (lane_ctl),
                .i_active (r_s1_mask[ROW] & r_s1_mask[COL]),
                .i_a      (r_s1_feat[ROW]),
                .i_b      (r_s1_feat[COL]),
                .o_sum    (pair_sum[g])
            );
            assign words[1 + MAX_FEATURES + g] = pair_sum[g];
        end
    endgenerate

    assign words[0] = ACC_W'(n_count);

    ma_readout u_readout (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap       (snap),
        .i_words      (words),
        .i_n          (num_active),
        .i_sat        (n_sat),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_overflow   (o_overflow),
        .o_last_word  (o_last_word)
    );

endmodule

// File: tb/sv/tb_moment_accumulator.sv
`timescale 1ns / 1ps

module tb_moment_accumulator;
    import ma_pkg::*;

    localparam int FEAT_W    = 16;
    localparam int BIG_BATCH = 24;
    localparam int RANDOM_REQUESTS = 320;

    typedef logic [MAX_FEATURES-1:0][FEAT_W-1:0] t_feature_set;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ACC_W-1:0] value;
        logic             overflow;
        logic             last_word;
    } t_readout_word;

    class moment_checker;
        logic [NUM_W-1:0] feature_cfg;
        logic [CNT_W-1:0] item_count;
        logic [LIN_W-1:0] lin_sum [MAX_FEATURES];
        logic [ACC_W-1:0] pair_sum [NUM_PAIRS];
        logic             saturated;
        t_readout_word    pending_words [$];
        int               mismatches;

        function new();
            feature_cfg = NUM_W'(MAX_FEATURES);
            mismatches  = 0;
            clear_store();
        endfunction

        function void clear_store();
            item_count = '0;
            saturated  = 1'b0;
            foreach (lin_sum[i]) lin_sum[i] = '0;
            foreach (pair_sum[i]) pair_sum[i] = '0;
        endfunction

        function void set_features(logic [NUM_W-1:0] cfg);
            feature_cfg = cfg;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void queue_word(int k, int total, logic [ACC_W-1:0] value);
            t_readout_word w;
            w.index     = IDX_W'(k);
            w.value     = value;
            w.overflow  = saturated;
            w.last_word = (k == total - 1);
            pending_words.push_back(w);
        endfunction

        function void accumulate_request(t_feature_set f, bit last);
            logic signed [FEAT_W-1:0] x [MAX_FEATURES];
            longint                   prod;
            int                       n;
            int                       k;
            int                       total;
            int                       slot;
            int                       i;
            int                       j;
            n = int'(feature_cfg);
            if (n == 0) begin
                n = 1;
            end
            if (n > MAX_FEATURES) begin
                n = MAX_FEATURES;
            end
            for (i = 0; i < MAX_FEATURES; i++) begin
                x[i] = f[i];
            end
            if (item_count == {CNT_W{1'b1}}) begin
                saturated = 1'b1;
            end else begin
                item_count = item_count + 1'b1;
            end
            for (i = 0; i < n; i++) begin
                lin_sum[i] = lin_sum[i] + {{(LIN_W-FEAT_W){x[i][FEAT_W-1]}}, x[i]};
            end
            slot = 0;
            for (i = 0; i < MAX_FEATURES; i++) begin
                for (j = i; j < MAX_FEATURES; j++) begin
                    if (j < n) begin
                        prod = longint'(x[i]) * longint'(x[j]);
                        pair_sum[slot] = pair_sum[slot] + prod[ACC_W-1:0];
                    end
                    slot++;
                end
            end
            if (!last) begin
                return;
            end
            total = 1 + n + (n * (n + 1)) / 2;
            k = 0;
            queue_word(k, total, ACC_W'(item_count));
            k++;
            for (i = 0; i < n; i++) begin
                queue_word(k, total, {{(ACC_W-LIN_W){lin_sum[i][LIN_W-1]}}, lin_sum[i]});
                k++;
            end
            slot = 0;
            for (i = 0; i < MAX_FEATURES; i++) begin
                for (j = i; j < MAX_FEATURES; j++) begin
                    if (j < n) begin
                        queue_word(k, total, pair_sum[slot]);
                        k++;
                    end
                    slot++;
                end
            end
            clear_store();
        endfunction

        function void check_word(t_readout_word got);
            t_readout_word exp;
            if (pending_words.size() == 0) begin
                $error("readout word with index %0d arrived with nothing expected", got.index);
                mismatches++;
                return;
            end
            exp = pending_words.pop_front();
            if (got.index !== exp.index) begin
                $error("word_index: expected %0d, actual %0d", exp.index, got.index);
                mismatches++;
            end
            if (got.value !== exp.value) begin
                $error("word_value: expected %h, actual %h", exp.value, got.value);
                mismatches++;
            end
            if (got.overflow !== exp.overflow) begin
                $error("overflow: expected %0b, actual %0b", exp.overflow, got.overflow);
                mismatches++;
            end
            if (got.last_word !== exp.last_word) begin
                $error("last_word: expected %0b, actual %0b", exp.last_word, got.last_word);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [FEAT_W-1:0] i_feature_a;
    logic signed [FEAT_W-1:0] i_feature_b;
    logic signed [FEAT_W-1:0] i_feature_c;
    logic signed [FEAT_W-1:0] i_feature_d;
    logic signed [FEAT_W-1:0] i_feature_e;
    logic                     i_last_item;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [NUM_W-1:0]         i_cfg_data;
    logic                     o_valid;
    logic                     i_stall;
    logic [IDX_W-1:0]         o_word_index;
    logic signed [ACC_W-1:0]  o_word_value;
    logic                     o_overflow;
    logic                     o_last_word;

    moment_checker sb;
    bit            quiet;

    moment_accumulator #(
        .FEATURE_BITS(FEAT_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_feature_a  (i_feature_a),
        .i_feature_b  (i_feature_b),
        .i_feature_c  (i_feature_c),
        .i_feature_d  (i_feature_d),
        .i_feature_e  (i_feature_e),
        .i_last_item  (i_last_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_overflow   (o_overflow),
        .o_last_word  (o_last_word)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word('{o_word_index, o_word_value, o_overflow, o_last_word});
        end
    end

    task automatic send_request(t_feature_set f, bit last);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_feature_a <= f[0];
        i_feature_b <= f[1];
        i_feature_c <= f[2];
        i_feature_d <= f[3];
        i_feature_e <= f[4];
        i_last_item <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.accumulate_request(f, last);
    endtask

    task automatic drain_readout();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_feature_count(logic [NUM_W-1:0] cfg);
        drain_readout();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cfg;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        sb.set_features(cfg);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_feature_set f;
        int           sent;
        int           phase;
        int           batches;
        int           len;
        bit           last;
        sb          = new();
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_feature_a = '0;
        i_feature_b = '0;
        i_feature_c = '0;
        i_feature_d = '0;
        i_feature_e = '0;
        i_last_item = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full feature set straight out of reset: extremes and alternating bits.
        send_request({MAX_FEATURES{16'h7FFF}}, 1'b0);
        send_request({MAX_FEATURES{16'h8000}}, 1'b0);
        send_request('0, 1'b0);
        send_request({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0);
        send_request({16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000, 16'hFFFF}, 1'b1);

        set_feature_count(3'd1);
        send_request({MAX_FEATURES{16'h8000}}, 1'b1);
        set_feature_count(3'd0);
        send_request({16'h1234, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, 1'b1);
        set_feature_count(3'd7);
        send_request({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
        send_request({16'hFFFF, 16'h0001, 16'h4000, 16'hC000, 16'h7FFF}, 1'b1);
        set_feature_count(3'd6);
        send_request({16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h8001}, 1'b1);

        // Requests with only two active features, then more features in the same batch.
        set_feature_count(3'd2);
        send_request({16'h7FFF, 16'h8000, 16'h1111, 16'h2222, 16'h3333}, 1'b0);
        send_request({16'h0100, 16'hFF00, 16'h4444, 16'h5555, 16'h6666}, 1'b0);
        set_feature_count(3'd4);
        send_request({16'h0003, 16'hFFFD, 16'h0007, 16'h8000, 16'h7FFF}, 1'b0);
        send_request({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1);
        set_feature_count(3'd3);
        send_request({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1);

        // One long batch of extreme values with no idling on either side.
        set_feature_count(3'd5);
        quiet = 1'b1;
        for (int t = 0; t < BIG_BATCH; t++) begin
            send_request({MAX_FEATURES{16'h8000}}, t == BIG_BATCH - 1);
        end
        quiet = 1'b0;

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_REQUESTS) begin
            set_feature_count(NUM_W'($urandom_range(0, 7)));
            quiet   = (phase == 3);
            batches = $urandom_range(1, 4);
            for (int b = 0; b < batches; b++) begin
                len = $urandom_range(1, 12);
                for (int t = 0; t < len; t++) begin
                    for (int i = 0; i < MAX_FEATURES; i++) begin
                        case ($urandom_range(7))
                            0:       f[i] = 16'h8000;
                            1:       f[i] = 16'h7FFF;
                            default: f[i] = FEAT_W'($urandom());
                        endcase
                    end
                    last = (t == len - 1);
                    if (last && b == batches - 1 && $urandom_range(9) == 0) begin
                        last = 1'b0;
                    end
                    send_request(f, last);
                    sent++;
                end
            end
            quiet = 1'b0;
            phase++;
        end

        drain_readout();
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/ma_pkg.sv
rtl/core/ma_pair_lane.sv
rtl/core/ma_lin_lane.sv
rtl/core/ma_readout.sv
rtl/core/moment_accumulator.sv
tb/sv/tb_moment_accumulator.sv
